@@ src/rbsi_pkg.sv @@
// Shared types and constants for the ray against box slab intersection block.
package rbsi_pkg;

   localparam int NUM_AXES    = 3;
   localparam int DATA_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int NUM_STAGES  = 6;

   // Register indexes of the box corners
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MAX_Z = 3'd5;

   // Saturation limits of a Q16.16 distance
   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [DATA_W-1:0] origin_x;
      logic signed [DATA_W-1:0] origin_y;
      logic signed [DATA_W-1:0] origin_z;
      logic signed [DATA_W-1:0] inv_dir_x;
      logic signed [DATA_W-1:0] inv_dir_y;
      logic signed [DATA_W-1:0] inv_dir_z;
      logic signed [DATA_W-1:0] ray_t_low;
      logic signed [DATA_W-1:0] ray_t_high;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] t_enter;
      logic signed [DATA_W-1:0] t_exit;
   } rsp_type;

endpackage

@@ src/ray_box_slab_intersect.sv @@
// Ray against axis-aligned box intersection, slab method, six-stage pipeline.
//
// Tests one ray per transaction against the box held in the six box corner
// registers (index 0..2 lower corner x/y/z, 3..5 upper corner x/y/z, signed
// Q16.16, reset 0; writes to other indexes are dropped). Transactions are
// accepted one per clock unless the output is stalled with every stage full,
// and bubbles close up while the output waits. The second stage holds six
// parallel 33x32 slab multipliers, and three interval compares follow them.
// A miss returns hit 0 with both distances 0. Write the box only while no
// transaction is in flight.
module ray_box_slab_intersect (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rbsi_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rbsi_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_en,
   input  logic [rbsi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rbsi_pkg::DATA_W-1:0]        csr_wdata
);

   localparam int NA = rbsi_pkg::NUM_AXES;
   localparam int NS = rbsi_pkg::NUM_STAGES;
   localparam int DW = rbsi_pkg::DATA_W;

   // Floor shift by 16 of a Q33.32 product, then clamp to 32 bits
   function automatic logic signed [DW-1:0] sat_q(input logic signed [2*DW:0] p);
      logic signed [DW-1:0] q;
      if (p[2*DW:DW+15] == {(DW-14){p[2*DW]}}) begin
         q = p[DW+15:16];
      end else if (p[2*DW]) begin
         q = rbsi_pkg::SAT_MIN;
      end else begin
         q = rbsi_pkg::SAT_MAX;
      end
      return q;
   endfunction

   // Box registers
   logic signed [DW-1:0] box_min_ff [NA];
   logic signed [DW-1:0] box_max_ff [NA];

   // Pipeline control
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] en;

   // Stage 1: plane minus origin
   logic signed [DW-1:0] orig     [NA];
   logic signed [DW-1:0] inv      [NA];
   logic signed [DW:0]   dmin_in  [NA];
   logic signed [DW:0]   dmax_in  [NA];
   logic signed [DW:0]   dmin_ff  [NA];
   logic signed [DW:0]   dmax_ff  [NA];
   logic signed [DW-1:0] inv1_ff  [NA];
   logic signed [DW-1:0] tlo1_ff, thi1_ff;

   // Stage 2: products
   logic signed [2*DW:0] pmin_in  [NA];
   logic signed [2*DW:0] pmax_in  [NA];
   logic signed [2*DW:0] pmin_ff  [NA];
   logic signed [2*DW:0] pmax_ff  [NA];
   logic [NA-1:0]        neg2_ff;
   logic signed [DW-1:0] tlo2_ff, thi2_ff;

   // Stage 3: near and far distances per axis
   logic signed [DW-1:0] near_in  [NA];
   logic signed [DW-1:0] far_in   [NA];
   logic signed [DW-1:0] near_ff  [NA];
   logic signed [DW-1:0] far_ff   [NA];
   logic signed [DW-1:0] tlo3_ff, thi3_ff;

   // Stage 4: x and y combined
   logic signed [DW-1:0] lo4_in, hi4_in, lo4_ff, hi4_ff;
   logic                 miss4_in, miss4_ff;
   logic signed [DW-1:0] nz4_ff, fz4_ff, tlo4_ff, thi4_ff;

   // Stage 5: z combined
   logic signed [DW-1:0] lo5_in, hi5_in, lo5_ff, hi5_ff;
   logic                 miss5_in, miss5_ff;
   logic signed [DW-1:0] tlo5_ff, thi5_ff;

   // Stage 6: clip and output register
   logic              miss6;
   rbsi_pkg::rsp_type rsp_in, rsp_ff;

   // Write box registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NA; a++) begin
            box_min_ff[a] <= '0;
            box_max_ff[a] <= '0;
         end
      end else if (csr_write_en) begin
         case (csr_index)
            rbsi_pkg::CSR_BOX_MIN_X: box_min_ff[0] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MIN_Y: box_min_ff[1] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MIN_Z: box_min_ff[2] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_X: box_max_ff[0] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_Y: box_max_ff[1] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_Z: box_max_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance a stage when it is empty or the next one advances
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int k = NS-2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in = {valid_ff[NS-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !en[0];

   // Stage 1: differences
   always_comb begin
      orig[0] = req_data.origin_x;
      orig[1] = req_data.origin_y;
      orig[2] = req_data.origin_z;
      inv[0]  = req_data.inv_dir_x;
      inv[1]  = req_data.inv_dir_y;
      inv[2]  = req_data.inv_dir_z;
      for (int a = 0; a < NA; a++) begin
         dmin_in[a] = {box_min_ff[a][DW-1], box_min_ff[a]} - {orig[a][DW-1], orig[a]};
         dmax_in[a] = {box_max_ff[a][DW-1], box_max_ff[a]} - {orig[a][DW-1], orig[a]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int a = 0; a < NA; a++) begin
            dmin_ff[a] <= dmin_in[a];
            dmax_ff[a] <= dmax_in[a];
            inv1_ff[a] <= inv[a];
         end
         tlo1_ff <= req_data.ray_t_low;
         thi1_ff <= req_data.ray_t_high;
      end
   end

   // Stage 2: one multiplier per slab plane
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         pmin_in[a] = dmin_ff[a] * inv1_ff[a];
         pmax_in[a] = dmax_ff[a] * inv1_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int a = 0; a < NA; a++) begin
            pmin_ff[a] <= pmin_in[a];
            pmax_ff[a] <= pmax_in[a];
            neg2_ff[a] <= inv1_ff[a][DW-1];
         end
         tlo2_ff <= tlo1_ff;
         thi2_ff <= thi1_ff;
      end
   end

   // Stage 3: scale, saturate, swap planes for a negative direction
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         near_in[a] = neg2_ff[a] ? sat_q(pmax_ff[a]) : sat_q(pmin_ff[a]);
         far_in[a]  = neg2_ff[a] ? sat_q(pmin_ff[a]) : sat_q(pmax_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int a = 0; a < NA; a++) begin
            near_ff[a] <= near_in[a];
            far_ff[a]  <= far_in[a];
         end
         tlo3_ff <= tlo2_ff;
         thi3_ff <= thi2_ff;
      end
   end

   // Stage 4: intersect the x and y intervals
   always_comb begin
      miss4_in = (near_ff[1] > far_ff[0]) || (far_ff[1] < near_ff[0]);
      lo4_in   = (near_ff[1] > near_ff[0]) ? near_ff[1] : near_ff[0];
      hi4_in   = (far_ff[1] < far_ff[0]) ? far_ff[1] : far_ff[0];
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         lo4_ff   <= lo4_in;
         hi4_ff   <= hi4_in;
         miss4_ff <= miss4_in;
         nz4_ff   <= near_ff[2];
         fz4_ff   <= far_ff[2];
         tlo4_ff  <= tlo3_ff;
         thi4_ff  <= thi3_ff;
      end
   end

   // Stage 5: intersect with the z interval
   always_comb begin
      miss5_in = miss4_ff || (nz4_ff > hi4_ff) || (fz4_ff < lo4_ff);
      lo5_in   = (nz4_ff > lo4_ff) ? nz4_ff : lo4_ff;
      hi5_in   = (fz4_ff < hi4_ff) ? fz4_ff : hi4_ff;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         lo5_ff   <= lo5_in;
         hi5_ff   <= hi5_in;
         miss5_ff <= miss5_in;
         tlo5_ff  <= tlo4_ff;
         thi5_ff  <= thi4_ff;
      end
   end

   // Stage 6: test against the ray interval and clip
   always_comb begin
      miss6 = miss5_ff || (lo5_ff > thi5_ff) || (hi5_ff < tlo5_ff);
      if (miss6) begin
         rsp_in.hit     = 1'b0;
         rsp_in.t_enter = '0;
         rsp_in.t_exit  = '0;
      end else begin
         rsp_in.hit     = 1'b1;
         rsp_in.t_enter = (lo5_ff < tlo5_ff) ? tlo5_ff : lo5_ff;
         rsp_in.t_exit  = (hi5_ff > thi5_ff) ? thi5_ff : hi5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[NS-1];
   assign rsp_data  = rsp_ff;

   // A miss always carries zero distances
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.t_enter == '0 && rsp_data.t_exit == '0))
      else $error("miss result with non-zero distances");

   // The input only stalls when the first stage holds a transaction
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff[0])
      else $error("input stalled with an empty first stage");

   // A blocked transaction stays in its stage
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !en[3]) |=> valid_ff[2])
      else $error("blocked transaction dropped from stage three");

   // A taken result with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !valid_ff[NS-2]) |=> !rsp_valid)
      else $error("result repeated after it was taken");

endmodule

@@ dv/rbsi_tb_pkg.sv @@
// Scoreboard class that predicts and checks the ray against box results.
`timescale 1ns / 1ps
package rbsi_tb_pkg;
   import rbsi_pkg::*;

   typedef logic signed [DATA_W-1:0] q16_t;

   class ray_box_checker;
      rsp_type pending_hits[$];
      q16_t    box_lo[NUM_AXES];
      q16_t    box_hi[NUM_AXES];
      int      mismatches;

      function new();
         for (int a = 0; a < NUM_AXES; a++) begin
            box_lo[a] = '0;
            box_hi[a] = '0;
         end
         mismatches = 0;
      endfunction

      // Mirror a register write; indexes past the upper corner are dropped
      function void note_box(logic [CSR_INDEX_W-1:0] index, logic [DATA_W-1:0] value);
         if (index <= CSR_BOX_MIN_Z)
            box_lo[index] = value;
         else if (index <= CSR_BOX_MAX_Z)
            box_hi[index - CSR_BOX_MAX_X] = value;
      endfunction

      // (plane - origin) * inv as an exact product, floored to Q16.16, then saturated
      function q16_t slab_distance(q16_t plane, q16_t origin, q16_t inv);
         logic signed [DATA_W:0]     gap;
         logic signed [2*DATA_W+1:0] prod;
         logic signed [2*DATA_W+1:0] scaled;
         gap    = {plane[DATA_W-1], plane} - {origin[DATA_W-1], origin};
         prod   = $signed({{(DATA_W+1){gap[DATA_W]}}, gap})
                * $signed({{(DATA_W+2){inv[DATA_W-1]}}, inv});
         scaled = prod >>> 16;
         if (scaled[2*DATA_W+1:DATA_W-1] != {(DATA_W+3){scaled[2*DATA_W+1]}})
            return scaled[2*DATA_W+1] ? SAT_MIN : SAT_MAX;
         return scaled[DATA_W-1:0];
      endfunction

      // Intersect the three slabs in x, y, z order, then clip to the ray interval
      function rsp_type slab_hit(req_type ray);
         q16_t    org[NUM_AXES];
         q16_t    inv[NUM_AXES];
         q16_t    t_near, t_far, span_lo, span_hi;
         logic    gone;
         rsp_type res;
         org[0]  = ray.origin_x;
         org[1]  = ray.origin_y;
         org[2]  = ray.origin_z;
         inv[0]  = ray.inv_dir_x;
         inv[1]  = ray.inv_dir_y;
         inv[2]  = ray.inv_dir_z;
         gone    = 1'b0;
         span_lo = '0;
         span_hi = '0;
         for (int a = 0; a < NUM_AXES; a++) begin
            if (!gone) begin
               // A zero inverse direction counts as non-negative
               if (!inv[a][DATA_W-1]) begin
                  t_near = slab_distance(box_lo[a], org[a], inv[a]);
                  t_far  = slab_distance(box_hi[a], org[a], inv[a]);
               end else begin
                  t_near = slab_distance(box_hi[a], org[a], inv[a]);
                  t_far  = slab_distance(box_lo[a], org[a], inv[a]);
               end
               if (a == 0) begin
                  span_lo = t_near;
                  span_hi = t_far;
               end else if (t_near > span_hi || t_far < span_lo) begin
                  gone = 1'b1;
               end else begin
                  if (t_near > span_lo) span_lo = t_near;
                  if (t_far < span_hi) span_hi = t_far;
               end
            end
         end
         if (!gone && (span_lo > ray.ray_t_high || span_hi < ray.ray_t_low))
            gone = 1'b1;
         res = '0;
         if (!gone) begin
            res.hit     = 1'b1;
            res.t_enter = (span_lo < ray.ray_t_low) ? ray.ray_t_low : span_lo;
            res.t_exit  = (span_hi > ray.ray_t_high) ? ray.ray_t_high : span_hi;
         end
         return res;
      endfunction

      function void note_ray(req_type ray);
         pending_hits.push_back(slab_hit(ray));
      endfunction

      // Count a failure; report only the first few
      function void flag(string what);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s", $time, what);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_hits.size() == 0) begin
            flag($sformatf("result with nothing outstanding: hit %0d t_enter %h t_exit %h",
                           got.hit, got.t_enter, got.t_exit));
            return;
         end
         want = pending_hits.pop_front();
         if (got.hit !== want.hit || got.t_enter !== want.t_enter
             || got.t_exit !== want.t_exit)
            flag($sformatf({"wrong result: hit expected %0d got %0d, ",
                            "t_enter expected %h got %h, t_exit expected %h got %h"},
                           want.hit, got.hit, want.t_enter, got.t_enter,
                           want.t_exit, got.t_exit));
      endfunction
   endclass

endpackage

@@ dv/tb_ray_box_slab_intersect.sv @@
// Testbench top for the ray against box slab intersection block.
`timescale 1ns / 1ps
module tb_ray_box_slab_intersect;
   import rbsi_pkg::*;
   import rbsi_tb_pkg::*;

   localparam int   CYCLE_LIMIT    = 400000;
   localparam int   RANDOM_PHASES  = 5;
   localparam int   RAYS_PER_PHASE = 250;
   localparam q16_t Q_ONE          = 32'sh0001_0000;
   localparam q16_t Q_NEG_ONE      = 32'shFFFF_0000;
   localparam q16_t Q_HALF         = 32'sh0000_8000;
   localparam q16_t Q_TWO          = 32'sh0002_0000;
   localparam q16_t Q_THREE        = 32'sh0003_0000;
   localparam q16_t Q_FIVE         = 32'sh0005_0000;

   typedef enum logic [1:0] {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY, DRAIN_BLOCKY} drain_mode_t;
   typedef enum logic [1:0] {BOX_MODERATE, BOX_EXTREME, BOX_INVERTED, BOX_RAW} box_kind_t;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_type                req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [DATA_W-1:0]      csr_wdata    = '0;

   ray_box_checker board;
   q16_t           corner_lo[NUM_AXES] = '{default: '0};
   q16_t           corner_hi[NUM_AXES] = '{default: '0};
   box_kind_t      box_plan[RANDOM_PHASES] =
                   '{BOX_MODERATE, BOX_EXTREME, BOX_MODERATE, BOX_INVERTED, BOX_RAW};
   int             burst_left = 0;
   bit             paced      = 1'b1;
   int             cycles     = 0;
   drain_mode_t    drain_mode = DRAIN_FREE;
   int             drain_left = 0;

   ray_box_slab_intersect dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Check each result transaction; stall on a pattern that changes now and then
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_data);
      if (drain_left == 0) begin
         drain_mode <= drain_mode_t'($urandom_range(0, 3));
         drain_left <= $urandom_range(32, 200);
      end else begin
         drain_left <= drain_left - 1;
      end
      case (drain_mode)
         DRAIN_FREE: rsp_stall <= 1'b0;
         DRAIN_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         DRAIN_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (drain_left % 16 < 12);
      endcase
   end

   // Uniform value between two bounds in either order, clamped to 32 bits
   function automatic q16_t pick_between(longint a, longint b);
      longint lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (lo < longint'(SAT_MIN)) lo = SAT_MIN;
      if (hi > longint'(SAT_MAX)) hi = SAT_MAX;
      return q16_t'(lo + longint'($urandom) % (hi - lo + 1));
   endfunction

   function automatic q16_t pick_inv();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return SAT_MAX;
         2: return SAT_MIN;
         3: return $urandom_range(0, 1) ? q16_t'(1) : q16_t'(-1);
         default: return pick_between(-longint'(Q_ONE) * 4, longint'(Q_ONE) * 4);
      endcase
   endfunction

   // Origin coordinate inside the box, or around it with a margin
   function automatic q16_t pick_coord(int axis, bit inside_box);
      longint lo, hi, margin;
      lo = (corner_lo[axis] < corner_hi[axis]) ? corner_lo[axis] : corner_hi[axis];
      hi = (corner_lo[axis] < corner_hi[axis]) ? corner_hi[axis] : corner_lo[axis];
      margin = inside_box ? 0 : (hi - lo) + longint'(Q_ONE);
      return pick_between(lo - margin, hi + margin);
   endfunction

   function automatic req_type make_ray(q16_t ox, q16_t oy, q16_t oz, q16_t ix, q16_t iy,
                                        q16_t iz, q16_t t_lo, q16_t t_hi);
      return {ox, oy, oz, ix, iy, iz, t_lo, t_hi};
   endfunction

   // Mostly rays started inside the box or around it, some pure noise
   function automatic req_type random_ray();
      req_type ray;
      int      kind;
      kind = $urandom_range(0, 99);
      if (kind >= 85)
         return {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
      ray.origin_x  = pick_coord(0, kind < 30);
      ray.origin_y  = pick_coord(1, kind < 30);
      ray.origin_z  = pick_coord(2, kind < 30);
      ray.inv_dir_x = pick_inv();
      ray.inv_dir_y = pick_inv();
      ray.inv_dir_z = pick_inv();
      case ($urandom_range(0, 7))
         0, 1, 2: begin
            ray.ray_t_low  = '0;
            ray.ray_t_high = SAT_MAX;
         end
         3: begin
            ray.ray_t_low  = SAT_MIN;
            ray.ray_t_high = SAT_MAX;
         end
         4: begin
            ray.ray_t_low  = $urandom;
            ray.ray_t_high = $urandom;
         end
         default: begin
            ray.ray_t_low  = pick_between(-(64'sd1 <<< 23), 64'sd1 <<< 23);
            ray.ray_t_high = pick_between(-(64'sd1 <<< 23), 64'sd1 <<< 23);
         end
      endcase
      return ray;
   endfunction

   // Hold the transaction until accepted, then note it
   task automatic send_ray(req_type ray);
      req_valid <= 1'b1;
      req_data  <= ray;
      do @(posedge clock); while (req_stall);
      board.note_ray(ray);
   endtask

   // Send in bursts; when paced, most bursts follow a random gap
   task automatic send_paced(req_type ray);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (paced && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      send_ray(ray);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, q16_t value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      board.note_box(index, value);
   endtask

   task automatic load_box(q16_t lx, q16_t ly, q16_t lz, q16_t hx, q16_t hy, q16_t hz);
      corner_lo = '{lx, ly, lz};
      corner_hi = '{hx, hy, hz};
      write_csr(CSR_BOX_MIN_X, lx);
      write_csr(CSR_BOX_MIN_Y, ly);
      write_csr(CSR_BOX_MIN_Z, lz);
      write_csr(CSR_BOX_MAX_X, hx);
      write_csr(CSR_BOX_MAX_Y, hy);
      write_csr(CSR_BOX_MAX_Z, hz);
      // A write past the upper corner must leave the box alone
      write_csr(CSR_BOX_MAX_Z + CSR_INDEX_W'($urandom_range(1, 2)), q16_t'($urandom));
      csr_write_en <= 1'b0;
   endtask

   task automatic load_random_box(box_kind_t kind);
      q16_t   lo[NUM_AXES];
      q16_t   hi[NUM_AXES];
      longint centre, half;
      for (int a = 0; a < NUM_AXES; a++) begin
         centre = pick_between(-longint'(Q_ONE) * 64, longint'(Q_ONE) * 64);
         half   = pick_between(longint'(Q_ONE) / 16, longint'(Q_ONE) * 16);
         case (kind)
            BOX_MODERATE: begin
               lo[a] = q16_t'(centre - half);
               hi[a] = q16_t'(centre + half);
            end
            BOX_INVERTED: begin
               lo[a] = q16_t'(centre + half);
               hi[a] = q16_t'(centre - half);
            end
            BOX_EXTREME: begin
               lo[a] = SAT_MIN;
               hi[a] = SAT_MAX;
            end
            default: begin
               lo[a] = $urandom;
               hi[a] = $urandom;
            end
         endcase
      end
      load_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endtask

   // Drop valid, wait for every outstanding result, then let the pipeline empty
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (board.pending_hits.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 2) @(posedge clock);
   endtask

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Box at reset: both planes of every axis sit at zero
      send_paced(make_ray(Q_ONE, Q_NEG_ONE, Q_THREE, Q_ONE, Q_ONE, Q_ONE, Q_NEG_ONE, Q_ONE));
      send_paced(make_ray('0, '0, '0, '0, '0, '0, '0, '0));
      settle_pipeline();

      // Unit box around the origin
      load_box(Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, Q_ONE);
      send_paced(make_ray('0, '0, '0, Q_ONE, Q_ONE, Q_ONE, SAT_MIN, SAT_MAX));
      send_paced(make_ray('0, '0, '0, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, '0, SAT_MAX));
      send_paced(make_ray(Q_HALF, Q_HALF, Q_HALF, '0, '0, '0, Q_NEG_ONE, Q_ONE));
      send_paced(make_ray('0, Q_FIVE, '0, Q_ONE, Q_ONE, Q_ONE, SAT_MIN, SAT_MAX));
      send_paced(make_ray('0, '0, Q_FIVE, Q_ONE, Q_ONE, Q_ONE, SAT_MIN, SAT_MAX));
      send_paced(make_ray('0, '0, '0, Q_ONE, Q_ONE, Q_ONE, Q_TWO, Q_THREE));
      // Ray interval given high before low
      send_paced(make_ray('0, '0, '0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_NEG_ONE));
      // Saturation both ways and the most negative inverse direction
      send_paced(make_ray(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX,
                          SAT_MIN, SAT_MAX));
      send_paced(make_ray(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                          SAT_MIN, SAT_MAX));
      send_paced(make_ray(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                          SAT_MIN, SAT_MAX));
      // Floor rounding of products that are not whole in Q16.16
      send_paced(make_ray(32'sd3, 32'sd3, 32'sd3, 32'sd1, 32'sd1, 32'sd1, SAT_MIN, SAT_MAX));
      send_paced(make_ray(-32'sd3, -32'sd3, -32'sd3, -32'sd1, -32'sd1, -32'sd1,
                          SAT_MIN, SAT_MAX));
      send_paced(make_ray('1, '1, '1, '1, '1, '1, '1, '1));
      send_paced(make_ray(-Q_FIVE, Q_HALF, Q_HALF, Q_ONE, '0, '0, SAT_MIN, SAT_MAX));
      settle_pipeline();

      // Inverted box: lower corner above the upper one
      load_box(Q_ONE, Q_ONE, Q_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE);
      send_paced(make_ray('0, '0, '0, Q_ONE, Q_ONE, Q_ONE, SAT_MIN, SAT_MAX));
      send_paced(make_ray('0, '0, '0, Q_NEG_ONE, '0, '0, SAT_MIN, SAT_MAX));
      settle_pipeline();

      // Box spanning the whole range
      load_box(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX);
      send_paced(make_ray('0, '0, '0, Q_ONE, Q_ONE, Q_ONE, SAT_MIN, SAT_MAX));
      send_paced(make_ray(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN,
                          SAT_MIN, SAT_MAX));
      send_paced(make_ray(SAT_MIN, SAT_MIN, SAT_MIN, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE,
                          SAT_MIN, SAT_MAX));

      // Random rays against a new box per phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle_pipeline();
         load_random_box(box_plan[p]);
         paced = ($urandom_range(0, 3) != 0);
         repeat (RAYS_PER_PHASE) send_paced(random_ray());
      end
      settle_pipeline();

      if (board.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
